FILE: hw/rtl/ncp_pkg.sv
// ----------------------------------------------------------------------------
// N-gram class predictor package
// Shared constants, microcode types and the control program of the sequencer.
// ----------------------------------------------------------------------------
package ncp_pkg;

    localparam int NUM_CLASSES = 7;
    localparam int SYM_W       = 3;
    localparam int ACT_W       = 2;
    localparam int HB_W        = 5;
    localparam int CC_W        = 9;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CLS_W       = 3;

    localparam logic [ACT_W-1:0] ACT_LEARN   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_COUNT = 1'd1;

    localparam logic [CLS_W-1:0] FIRST_CLASS  = 3'd1;
    localparam logic [CLS_W-1:0] SECOND_CLASS = 3'd2;
    localparam logic [CLS_W-1:0] LAST_CLASS   = 3'(NUM_CLASSES - 1);

    typedef enum logic [3:0] {
        S_CLEAR         = 4'd0,
        S_IDLE          = 4'd1,
        S_MOD_CTX       = 4'd2,
        S_MOD_CTX_WAIT  = 4'd3,
        S_SET_CTX       = 4'd4,
        S_MUL_A         = 4'd5,
        S_MUL_B         = 4'd6,
        S_CMP           = 4'd7,
        S_OUT           = 4'd8,
        S_MOD_NEXT      = 4'd9,
        S_MOD_NEXT_WAIT = 4'd10,
        S_ADV           = 4'd11,
        S_KEEP          = 4'd12
    } t_step;

    typedef enum logic [2:0] {
        COND_NEXT       = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_WAIT_START = 3'd2,
        COND_CLR_MORE   = 3'd3,
        COND_MOD_BUSY   = 3'd4,
        COND_IDX_MORE   = 3'd5,
        COND_NO_ADVANCE = 3'd6
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  clr_wr;
        logic  mod_ld_ctx;
        logic  mod_ld_next;
        logic  set_ctx;
        logic  mul_a;
        logic  mul_b;
        logic  cmp;
        logic  out;
        logic  ctx_adv;
        logic  ctx_keep;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic clr_more;
        logic mod_busy;
        logic idx_more;
        logic no_advance;
    } t_flags;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '0;
        w.cond = COND_NEXT;
        w.target = S_CLEAR;
        unique case (step)
            S_CLEAR: begin
                w.busy = 1'b1; w.clr_wr = 1'b1;
                w.cond = COND_CLR_MORE; w.target = S_CLEAR;
            end
            S_IDLE: begin
                w.cond = COND_WAIT_START; w.target = S_IDLE;
            end
            S_MOD_CTX: begin
                w.busy = 1'b1; w.mod_ld_ctx = 1'b1;
            end
            S_MOD_CTX_WAIT: begin
                w.busy = 1'b1;
                w.cond = COND_MOD_BUSY; w.target = S_MOD_CTX_WAIT;
            end
            S_SET_CTX: begin
                w.busy = 1'b1; w.set_ctx = 1'b1;
            end
            S_MUL_A: begin
                w.busy = 1'b1; w.mul_a = 1'b1;
            end
            S_MUL_B: begin
                w.busy = 1'b1; w.mul_b = 1'b1;
            end
            S_CMP: begin
                w.busy = 1'b1; w.cmp = 1'b1;
                w.cond = COND_IDX_MORE; w.target = S_MUL_A;
            end
            S_OUT: begin
                w.busy = 1'b1; w.out = 1'b1;
                w.cond = COND_NO_ADVANCE; w.target = S_KEEP;
            end
            S_MOD_NEXT: begin
                w.busy = 1'b1; w.mod_ld_next = 1'b1;
            end
            S_MOD_NEXT_WAIT: begin
                w.busy = 1'b1;
                w.cond = COND_MOD_BUSY; w.target = S_MOD_NEXT_WAIT;
            end
            S_ADV: begin
                w.busy = 1'b1; w.ctx_adv = 1'b1;
                w.cond = COND_ALWAYS; w.target = S_IDLE;
            end
            S_KEEP: begin
                w.busy = 1'b1; w.ctx_keep = 1'b1;
                w.cond = COND_ALWAYS; w.target = S_IDLE;
            end
            default: begin
                w.busy = 1'b1;
                w.cond = COND_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/ncp_seq.sv
// ----------------------------------------------------------------------------
// N-gram class predictor sequencer
// Step counter with the control program table and conditional jumps.
// ----------------------------------------------------------------------------
module ncp_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ncp_pkg::t_flags i_flags,
    output ncp_pkg::t_ctrl  o_ctrl
);
    import ncp_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;
    logic  take;

    always_comb begin
        ctrl = ucode(r_step);
    end

    always_comb begin
        take = 1'b0;
        unique case (ctrl.cond)
            COND_NEXT:       take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_WAIT_START: take = !i_flags.start;
            COND_CLR_MORE:   take = i_flags.clr_more;
            COND_MOD_BUSY:   take = i_flags.mod_busy;
            COND_IDX_MORE:   take = i_flags.idx_more;
            COND_NO_ADVANCE: take = i_flags.no_advance;
            default:         take = 1'b1;
        endcase
        n_step = take ? ctrl.target : t_step'(r_step + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

FILE: hw/rtl/ncp_mod.sv
// ----------------------------------------------------------------------------
// N-gram class predictor modulo unit
// Restoring shift-subtract remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ncp_mod #(
    parameter int DVD_W = 13,
    parameter int DVS_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVS_W-1:0] o_rem
);
    localparam int CNTR_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [CNTR_W-1:0] r_cnt;
    logic [DVS_W:0]    trial;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNTR_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/ncp_mem.sv
// ----------------------------------------------------------------------------
// N-gram class predictor row memory
// One write port and one registered read port, one context row per word.
// ----------------------------------------------------------------------------
module ncp_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 112
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ngram_class_predictor_core.sv
// ----------------------------------------------------------------------------
// N-gram class predictor core
// Learns symbol counts per hashed context and predicts the best class.
// ----------------------------------------------------------------------------
// After reset the block sets every count in its memory to one, one row per
// cycle, and holds busy high meanwhile. An item is taken when start is high
// and busy is low. Its prediction appears on o_predicted_class with o_valid
// high for exactly one cycle, once the one-bit-per-cycle modulo unit has
// reduced the context; the receiver must take it in that cycle. An item that
// moves the context runs the modulo unit a second time after the prediction
// and keeps busy high until it is done; a predict-only item ends after its
// prediction. The five class comparisons share one multiplier.
// ----------------------------------------------------------------------------
module ngram_class_predictor_core #(
    parameter int CONTEXT_DEPTH = 256,
    parameter int COUNT_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ncp_pkg::ACT_W-1:0]       i_action,
    input  logic [ncp_pkg::SYM_W-1:0]       i_symbol,
    output logic                            o_valid,
    output logic [ncp_pkg::CLS_W-1:0]       o_predicted_class,
    input  logic                            i_cfg_we,
    input  logic [ncp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ncp_pkg::CFG_W-1:0]       i_cfg_data
);
    import ncp_pkg::*;

    localparam int CTX_W  = (CONTEXT_DEPTH > 1) ? $clog2(CONTEXT_DEPTH) : 1;
    localparam int CNT_W  = $clog2(CONTEXT_DEPTH + 1);
    localparam int EXT_W  = (CNT_W > CC_W) ? CNT_W : CC_W;
    localparam int DVD_W  = CTX_W + HB_W;
    localparam int ROW_W  = NUM_CLASSES * COUNT_BITS;
    localparam int PROD_W = 2 * COUNT_BITS;

    t_ctrl  ctrl;
    t_flags flags;

    logic [HB_W-1:0]       r_history_base;
    logic [CC_W-1:0]       r_context_count;
    logic [ACT_W-1:0]      r_action;
    logic [SYM_W-1:0]      r_symbol;
    logic [CTX_W-1:0]      r_context;
    logic [CTX_W-1:0]      r_ctx;
    logic [CTX_W-1:0]      r_clr_addr;
    logic [CLS_W-1:0]      r_best;
    logic [CLS_W-1:0]      r_idx;
    logic [PROD_W-1:0]     r_prod_a;
    logic [PROD_W-1:0]     r_prod_b;
    logic                  r_tb_zero;
    logic                  r_ti_zero;
    logic [COUNT_BITS-1:0] r_totals [NUM_CLASSES];
    logic                  r_valid;
    logic [CLS_W-1:0]      r_pred;

    logic                  accept;
    logic                  sym_ok;
    logic                  do_learn;
    logic                  do_advance;
    logic [EXT_W-1:0]      cc_ext;
    logic [CNT_W-1:0]      eff_count;
    logic [DVD_W-1:0]      mod_dividend;
    logic                  mod_busy;
    logic [CNT_W-1:0]      mod_rem;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      new_row;
    logic [CLS_W-1:0]      row_sel;
    logic [CLS_W-1:0]      tot_sel;
    logic [COUNT_BITS-1:0] row_val;
    logic [COUNT_BITS-1:0] tot_val;
    logic [PROD_W-1:0]     prod;
    logic                  wins;
    logic                  mem_we;
    logic [CTX_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    ncp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign busy   = ctrl.busy;
    assign accept = start && !ctrl.busy;

    assign sym_ok     = (r_symbol < SYM_W'(NUM_CLASSES));
    assign do_learn   = (r_action == ACT_LEARN) && sym_ok;
    assign do_advance = ((r_action == ACT_LEARN) || (r_action == ACT_ADVANCE)) && sym_ok;

    always_comb begin
        flags.start      = start;
        flags.clr_more   = (r_clr_addr != CTX_W'(CONTEXT_DEPTH - 1));
        flags.mod_busy   = mod_busy;
        flags.idx_more   = (r_idx != LAST_CLASS);
        flags.no_advance = !do_advance;
    end

    always_comb begin
        cc_ext = EXT_W'(r_context_count);
        if (cc_ext == '0) begin
            eff_count = CNT_W'(1);
        end else if (cc_ext > EXT_W'(CONTEXT_DEPTH)) begin
            eff_count = CNT_W'(CONTEXT_DEPTH);
        end else begin
            eff_count = cc_ext[CNT_W-1:0];
        end
    end

    always_comb begin
        if (ctrl.mod_ld_next) begin
            mod_dividend = DVD_W'(r_ctx) * DVD_W'(r_history_base) + DVD_W'(r_symbol);
        end else begin
            mod_dividend = DVD_W'(r_context);
        end
    end

    ncp_mod #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ctrl.mod_ld_ctx || ctrl.mod_ld_next),
        .i_dividend (mod_dividend),
        .i_divisor  (eff_count),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    always_comb begin
        new_row = row;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (r_symbol == SYM_W'(k)) begin
                new_row[k*COUNT_BITS +: COUNT_BITS] =
                    sat_inc(row[k*COUNT_BITS +: COUNT_BITS]);
            end
        end
    end

    always_comb begin
        if (ctrl.clr_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = {NUM_CLASSES{COUNT_BITS'(1)}};
        end else begin
            mem_we    = ctrl.out && do_learn;
            mem_waddr = r_ctx;
            mem_wdata = new_row;
        end
    end

    ncp_mem #(
        .DEPTH  (CONTEXT_DEPTH),
        .ADDR_W (CTX_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (ctrl.set_ctx),
        .i_raddr (mod_rem[CTX_W-1:0]),
        .o_rdata (row)
    );

    always_comb begin
        row_sel = ctrl.mul_a ? r_idx : r_best;
        tot_sel = ctrl.mul_a ? r_best : r_idx;
        row_val = '0;
        tot_val = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (row_sel == CLS_W'(k)) begin
                row_val = row[k*COUNT_BITS +: COUNT_BITS];
            end
            if (tot_sel == CLS_W'(k)) begin
                tot_val = r_totals[k];
            end
        end
    end

    assign prod = PROD_W'(row_val) * PROD_W'(tot_val);

    assign wins = !r_tb_zero && (r_ti_zero || (r_prod_a > r_prod_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_base  <= HB_W'(2);
            r_context_count <= CC_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HISTORY_BASE:  r_history_base  <= i_cfg_data[HB_W-1:0];
                CFG_CONTEXT_COUNT: r_context_count <= i_cfg_data[CC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_context  <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_totals[k] <= '0;
            end
        end else begin
            r_valid <= ctrl.out;
            if (ctrl.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (ctrl.ctx_adv) begin
                r_context <= mod_rem[CTX_W-1:0];
            end else if (ctrl.ctx_keep) begin
                r_context <= r_ctx;
            end
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (ctrl.out && do_learn && (r_symbol == SYM_W'(k))) begin
                    r_totals[k] <= sat_inc(r_totals[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_symbol <= i_symbol;
        end
        if (ctrl.set_ctx) begin
            r_ctx  <= mod_rem[CTX_W-1:0];
            r_best <= FIRST_CLASS;
            r_idx  <= SECOND_CLASS;
        end
        if (ctrl.mul_a) begin
            r_prod_a  <= prod;
            r_tb_zero <= (tot_val == '0);
        end
        if (ctrl.mul_b) begin
            r_prod_b  <= prod;
            r_ti_zero <= (tot_val == '0);
        end
        if (ctrl.cmp) begin
            if (wins) begin
                r_best <= r_idx;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (ctrl.out) begin
            r_pred <= r_best;
        end
    end

    assign o_valid           = r_valid;
    assign o_predicted_class = r_pred;

endmodule

FILE: bench/ngram_class_predictor_core_test.sv
// ----------------------------------------------------------------------------
// N-gram class predictor core testbench
// Drives learn, advance and predict words through the command port and
// checks every prediction against a cycle-free model of the count tables.
// Register settings change between bursts while the core is idle. The
// sender inserts idle gaps at several rates so that new words land on every
// phase of the core's sequencer.
// ----------------------------------------------------------------------------
module ngram_class_predictor_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ncp_pkg::*;

    localparam int ROWS    = 256;
    localparam int CLASSES = NUM_CLASSES;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [SYM_W-1:0] SYM_BAD   = 3'd7;

    class ngram_tracker;
        bit [15:0]              pair_tally [ROWS][CLASSES];
        bit [15:0]              class_total [CLASSES];
        int unsigned            ctx;
        bit [HB_W-1:0]          base;
        bit [CC_W-1:0]          span;
        logic [CLS_W-1:0]       expected_class [$];
        int                     errors;
        int                     checked;
        int                     action_seen [4];

        function new();
            foreach (pair_tally[r, c]) pair_tally[r][c] = 16'd1;
            foreach (class_total[c]) class_total[c] = 16'd0;
            foreach (action_seen[a]) action_seen[a] = 0;
            ctx = 0;
            base = 5'd2;
            span = 9'd4;
            errors = 0;
            checked = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_HISTORY_BASE) begin
                base = data[HB_W-1:0];
            end else begin
                span = data[CC_W-1:0];
            end
        endfunction

        function bit [CLS_W-1:0] best_class(int unsigned row);
            int unsigned best;
            longint unsigned lhs;
            longint unsigned rhs;
            best = 1;
            for (int i = 2; i < CLASSES; i++) begin
                lhs = pair_tally[row][i];
                lhs = lhs * class_total[best];
                rhs = pair_tally[row][best];
                rhs = rhs * class_total[i];
                if (class_total[best] != 0 && (class_total[i] == 0 || lhs > rhs)) begin
                    best = i;
                end
            end
            return best[CLS_W-1:0];
        endfunction

        function void note_word(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym);
            int unsigned eff;
            int unsigned row;
            eff = (span == 0) ? 1 : (span > ROWS) ? ROWS : span;
            row = ctx % eff;
            expected_class = {expected_class, best_class(row)};
            action_seen[act]++;
            ctx = row;
            if ((act == ACT_LEARN || act == ACT_ADVANCE) && sym < CLASSES) begin
                if (act == ACT_LEARN) begin
                    if (pair_tally[row][sym] != 16'hFFFF) pair_tally[row][sym]++;
                    if (class_total[sym] != 16'hFFFF) class_total[sym]++;
                end
                ctx = (row * base + sym) % eff;
            end
        endfunction

        function void check_result(logic [CLS_W-1:0] actual);
            logic [CLS_W-1:0] want;
            if (expected_class.size() == 0) begin
                $error("predicted_class word with none expected: actual %0d", actual);
                errors++;
            end else begin
                want = expected_class.pop_front();
                checked++;
                if (actual !== want) begin
                    $error("predicted_class mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_class.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ACT_W-1:0]       i_action = '0;
    logic [SYM_W-1:0]       i_symbol = '0;
    logic                   o_valid;
    logic [CLS_W-1:0]       o_predicted_class;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    ngram_tracker tracker;
    int sender_idle_pct = 0;
    int settings_used = 0;

    ngram_class_predictor_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_symbol          (i_symbol),
        .o_valid           (o_valid),
        .o_predicted_class (o_predicted_class),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) tracker.check_result(o_predicted_class);
            if (start && busy === 1'b0) tracker.note_word(i_action, i_symbol);
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym);
        i_action <= act;
        i_symbol <= sym;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while ((tracker.outstanding() != 0 || busy !== 1'b0) && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [HB_W-1:0] hb, input logic [CC_W-1:0] cc);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_HISTORY_BASE;
        i_cfg_data <= CFG_W'(hb);
        @(posedge i_clk);
        i_cfg_index <= CFG_CONTEXT_COUNT;
        i_cfg_data <= CFG_W'(cc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.write_register(CFG_HISTORY_BASE, CFG_W'(hb));
        tracker.write_register(CFG_CONTEXT_COUNT, CFG_W'(cc));
        settings_used++;
    endtask

    initial begin
        logic [ACT_W-1:0] act;
        logic [SYM_W-1:0] sym;
        logic [HB_W-1:0]  hb;
        logic [CC_W-1:0]  cc;
        logic [SYM_W-1:0] favorite;
        int               r;

        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        send_word(ACT_PREDICT, 3'd0);
        send_word(ACT_PREDICT, SYM_BAD);
        send_word(ACT_SPARE, 3'd5);
        for (int s = 0; s < CLASSES; s++) send_word(ACT_LEARN, SYM_W'(s));
        send_word(ACT_LEARN, SYM_BAD);
        send_word(ACT_ADVANCE, 3'd6);
        send_word(ACT_ADVANCE, SYM_BAD);
        send_word(ACT_LEARN, 3'd3);
        send_word(ACT_PREDICT, 3'd0);
        drain();
        apply_setting(5'd31, 9'd511);
        send_word(ACT_LEARN, 3'd6);
        send_word(ACT_LEARN, 3'd5);
        send_word(ACT_ADVANCE, 3'd4);
        send_word(ACT_LEARN, 3'd6);
        drain();
        apply_setting(5'd0, 9'd0);
        send_word(ACT_PREDICT, 3'd1);
        send_word(ACT_LEARN, 3'd2);
        send_word(ACT_ADVANCE, 3'd1);
        drain();
        apply_setting(5'd16, 9'd256);
        send_word(ACT_LEARN, 3'd6);
        send_word(ACT_ADVANCE, 3'd3);
        send_word(ACT_PREDICT, 3'd4);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 83 : 0;
            for (int chunk = 0; chunk < 5; chunk++) begin
                drain();
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(3))
                        0: hb = 5'd0;
                        1: hb = 5'd1;
                        2: hb = 5'd16;
                        default: hb = 5'd31;
                    endcase
                end else begin
                    hb = HB_W'($urandom_range(0, 31));
                end
                r = $urandom_range(9);
                if (r < 5) begin
                    cc = CC_W'($urandom_range(1, 8));
                end else if (r < 7) begin
                    case ($urandom_range(3))
                        0: cc = 9'd0;
                        1: cc = 9'd1;
                        2: cc = 9'd256;
                        default: cc = 9'd511;
                    endcase
                end else begin
                    cc = CC_W'($urandom_range(0, 511));
                end
                apply_setting(hb, cc);
                favorite = SYM_W'($urandom_range(0, 6));
                repeat (110) begin
                    r = $urandom_range(99);
                    if (r < 60) act = ACT_LEARN;
                    else if (r < 75) act = ACT_ADVANCE;
                    else if (r < 93) act = ACT_PREDICT;
                    else act = ACT_SPARE;
                    if ($urandom_range(19) == 0) sym = SYM_BAD;
                    else if ($urandom_range(1) == 1) sym = favorite;
                    else sym = SYM_W'($urandom_range(0, 6));
                    send_word(act, sym);
                end
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $error("predicted_class: %0d expected words never arrived",
                   tracker.outstanding());
            tracker.errors += tracker.outstanding();
        end

        $display("Sent %0d learn, %0d advance, %0d predict and %0d spare-action words",
                 tracker.action_seen[0], tracker.action_seen[1],
                 tracker.action_seen[2], tracker.action_seen[3]);
        $display("Checked %0d predictions across %0d register settings",
                 tracker.checked, settings_used + 1);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ncp_pkg.sv
hw/rtl/ncp_seq.sv
hw/rtl/ncp_mod.sv
hw/rtl/ncp_mem.sv
hw/rtl/ngram_class_predictor_core.sv
bench/ngram_class_predictor_core_test.sv
